/* rtl/core/serial_command_line_recognizer_core_assert.svh */
// assertion macros for the serial command line recognizer core
// expects signals named clock and reset in the module that uses them
`ifndef SERIAL_COMMAND_LINE_RECOGNIZER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_LINE_RECOGNIZER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define SCLR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sclr check failed");

// consequent holds in the cycle after the antecedent
`define SCLR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sclr check failed");

`endif

/* rtl/core/sclr_pkg.sv */
// shared types and constants of the serial command line recognizer
// no dependencies
package sclr_pkg;

   localparam int LINE_CAPACITY = 16;
   localparam int LINE_DEPTH    = LINE_CAPACITY - 1;
   localparam int LEN_W         = $clog2(LINE_CAPACITY);
   localparam int IDX_W         = $clog2(LINE_DEPTH);

   // bytes looked at when a line is committed: longest word plus its terminator
   localparam int PEEK_N = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   localparam logic [39:0] WORD_START = "START";
   localparam logic [31:0] WORD_STOP  = "STOP";
   localparam logic [15:0] WORD_GO    = "GO";

   typedef enum logic [1:0] {
      REPLY_START    = 2'd0,
      REPLY_STOP     = 2'd1,
      REPLY_UNKNOWN  = 2'd2,
      REPLY_TOO_LONG = 2'd3
   } reply_type;

   typedef struct packed {
      logic      valid;
      reply_type reply;
   } cmd_type;

endpackage

/* rtl/core/serial_command_line_recognizer_core.sv */
// the result of a byte that ends a command is queued, then registered for output
// throughput: one byte per cycle, held only by the two-entry command queue filling
//   when the result side stalls
// reset: line length zero, queue and output register empty, mode stopped;
//   the line store is not cleared and needs no clearing pass
module serial_command_line_recognizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_reply,
   output logic       rsp_mode_now,
   output logic       rsp_restart_follow
);
   import sclr_pkg::*;

   cmd_type   push;
   cmd_type   head;
   logic      pop;
   logic      full;
   logic      accept;
   reply_type reply;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   sclr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cmd_out (push)
   );

   sclr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   sclr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_reply          (reply),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_restart_follow (rsp_restart_follow)
   );

   assign rsp_reply = reply;

endmodule

/* rtl/core/sclr_front.sv */
// front end: line buffer, case folding and command classification
// depends on sclr_pkg
module sclr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output sclr_pkg::cmd_type cmd_out
);
   import sclr_pkg::*;

   logic [7:0]       line_store_ff [LINE_DEPTH];
   logic [LEN_W-1:0] line_length_ff;
   logic [LEN_W-1:0] line_length_in;
   logic [7:0]       folded;
   logic [7:0]       peek [PEEK_N];
   logic             store_en;
   logic             line_empty;
   reply_type        line_reply;
   logic             m_start;
   logic             m_go;
   logic             m_stop;
   logic             m_one;
   logic             m_zero;

   assign line_empty = (line_length_ff == '0);
   assign folded = (rx_byte >= CHAR_LOW_A && rx_byte <= CHAR_LOW_Z) ?
                   (rx_byte - CASE_OFFSET) : rx_byte;

   // bytes past the held length read as terminators
   for (genvar i = 0; i < PEEK_N; i++) begin : g_peek
      if (i < LINE_DEPTH) begin : g_held
         assign peek[i] = (LEN_W'(i) < line_length_ff) ? line_store_ff[i] : CHAR_NUL;
      end else begin : g_none
         assign peek[i] = CHAR_NUL;
      end
   end

   assign m_start = ({peek[0], peek[1], peek[2], peek[3], peek[4]} == WORD_START) &&
                    (peek[5] == CHAR_NUL);
   assign m_stop  = ({peek[0], peek[1], peek[2], peek[3]} == WORD_STOP) &&
                    (peek[4] == CHAR_NUL);
   assign m_go    = ({peek[0], peek[1]} == WORD_GO) && (peek[2] == CHAR_NUL);
   assign m_one   = (peek[0] == CHAR_ONE) && (peek[1] == CHAR_NUL);
   assign m_zero  = (peek[0] == CHAR_ZERO) && (peek[1] == CHAR_NUL);

   always_comb begin
      priority if (m_start || m_go || m_one) begin
         line_reply = REPLY_START;
      end else if (m_stop || m_zero) begin
         line_reply = REPLY_STOP;
      end else begin
         line_reply = REPLY_UNKNOWN;
      end
   end

   always_comb begin
      cmd_out.valid  = 1'b0;
      cmd_out.reply  = REPLY_UNKNOWN;
      store_en       = 1'b0;
      line_length_in = line_length_ff;
      priority if ((rx_byte == CHAR_ZERO || rx_byte == CHAR_ONE) && line_empty) begin
         cmd_out.valid = accept;
         cmd_out.reply = (rx_byte == CHAR_ONE) ? REPLY_START : REPLY_STOP;
      end else if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
         if (!line_empty) begin
            cmd_out.valid  = accept;
            cmd_out.reply  = line_reply;
            line_length_in = '0;
         end
      end else if (folded == CHAR_SPACE && line_empty) begin
         line_length_in = line_length_ff;
      end else if (line_length_ff < LEN_W'(LINE_DEPTH)) begin
         store_en       = accept;
         line_length_in = line_length_ff + 1'b1;
      end else begin
         // overflow drops the whole line
         cmd_out.valid  = accept;
         cmd_out.reply  = REPLY_TOO_LONG;
         line_length_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
      end else if (accept) begin
         line_length_ff <= line_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         line_store_ff[line_length_ff[IDX_W-1:0]] <= folded;
      end
   end

endmodule

/* rtl/core/sclr_queue.sv */
// two-entry command queue between front and back
// depends on sclr_pkg and the assertion macro header
module sclr_queue (
   input  logic             clock,
   input  logic             reset,
   input  sclr_pkg::cmd_type push,
   input  logic             pop,
   output sclr_pkg::cmd_type head,
   output logic             full
);
   import sclr_pkg::*;
   `include "serial_command_line_recognizer_core_assert.svh"

   reply_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.reply = entry_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.reply;
      end
   end

   `SCLR_ASSERT_ALWAYS(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `SCLR_ASSERT_ALWAYS(a_no_push_when_full, !(push.valid && full))
   `SCLR_ASSERT_ALWAYS(a_no_pop_when_empty, !(pop && count_ff == '0))
   `SCLR_ASSERT_NEXT(a_push_grows, push.valid && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

/* rtl/core/sclr_back.sv */
// back end: run/stop mode and the registered result word
// depends on sclr_pkg
module sclr_back (
   input  logic             clock,
   input  logic             reset,
   input  sclr_pkg::cmd_type head,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output sclr_pkg::reply_type rsp_reply,
   output logic             rsp_mode_now,
   output logic             rsp_restart_follow
);
   import sclr_pkg::*;

   logic      run_mode_ff;
   logic      run_mode_in;
   logic      restart_in;
   logic      rsp_valid_ff;
   reply_type rsp_reply_ff;
   logic      rsp_mode_ff;
   logic      rsp_restart_ff;
   logic      advance;

   // output register frees up when empty or when its word is taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = head.valid && advance;

   always_comb begin
      run_mode_in = run_mode_ff;
      restart_in  = 1'b0;
      unique case (head.reply)
         REPLY_START: begin
            run_mode_in = 1'b1;
            restart_in  = !run_mode_ff;
         end
         REPLY_STOP: begin
            run_mode_in = 1'b0;
         end
         REPLY_UNKNOWN, REPLY_TOO_LONG: begin
            run_mode_in = run_mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= head.valid;
         if (head.valid) begin
            run_mode_ff <= run_mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_reply_ff   <= head.reply;
         rsp_mode_ff    <= run_mode_in;
         rsp_restart_ff <= restart_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply          = rsp_reply_ff;
   assign rsp_mode_now       = rsp_mode_ff;
   assign rsp_restart_follow = rsp_restart_ff;

endmodule

/* dv/tb_serial_command_line_recognizer_core.sv */
// testbench for serial_command_line_recognizer_core: directed command lines, then random traffic
// depends on sclr_pkg and the core; replies are predicted in-line and checked in order
module tb_serial_command_line_recognizer_core;
   import sclr_pkg::*;

   typedef struct packed {
      reply_type reply;
      logic      mode_now;
      logic      restart_follow;
   } line_result_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_reply;
   logic       rsp_mode_now;
   logic       rsp_restart_follow;

   int idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int replies_checked = 0;
   int errors = 0;

   // predicted replies, oldest first
   line_result_type pending_replies[$];
   line_result_type oldest;

   // predictor state
   logic [7:0] line_buf [LINE_DEPTH];
   int         line_len = 0;
   logic       run_mode = 1'b0;

   string cmd_words [8] = '{"START", "GO", "STOP", "STAR", "GOO", "STOPP", "ST", "HALT"};

   serial_command_line_recognizer_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reply          (rsp_reply),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_restart_follow (rsp_restart_follow)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("** serial_command_line_recognizer_core: FAILED **");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual reply %0d mode %0b restart %0b",
                     $time, rsp_reply, rsp_mode_now, rsp_restart_follow);
            errors++;
         end else begin
            oldest = pending_replies.pop_front();
            if (rsp_reply !== oldest.reply) begin
               $display("%0t: reply expected %0d, actual %0d", $time, oldest.reply, rsp_reply);
               errors++;
            end
            if (rsp_mode_now !== oldest.mode_now) begin
               $display("%0t: mode_now expected %0b, actual %0b",
                        $time, oldest.mode_now, rsp_mode_now);
               errors++;
            end
            if (rsp_restart_follow !== oldest.restart_follow) begin
               $display("%0t: restart_follow expected %0b, actual %0b",
                        $time, oldest.restart_follow, rsp_restart_follow);
               errors++;
            end
            replies_checked++;
         end
      end
   end

   function automatic bit line_equals(input int n, input string w);
      if (n != w.len()) return 1'b0;
      for (int i = 0; i < n; i++) begin
         if (line_buf[i] != w[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic line_result_type apply_command(input bit is_start, input bit is_stop);
      line_result_type r;
      r.restart_follow = 1'b0;
      if (is_start) begin
         r.restart_follow = !run_mode;
         run_mode = 1'b1;
         r.reply = REPLY_START;
      end else if (is_stop) begin
         run_mode = 1'b0;
         r.reply = REPLY_STOP;
      end else begin
         r.reply = REPLY_UNKNOWN;
      end
      r.mode_now = run_mode;
      return r;
   endfunction

   // advances the line state by one word; returns 1 when the word is ignored
   function automatic bit recognize_byte(input logic [7:0] rx);
      logic [7:0]      ch;
      int              n;
      line_result_type r;
      ch = rx;
      if ((rx == CHAR_ONE || rx == CHAR_ZERO) && line_len == 0) begin
         pending_replies.push_back(apply_command(rx == CHAR_ONE, rx == CHAR_ZERO));
         return 1'b0;
      end
      if (rx == CHAR_CR || rx == CHAR_LF) begin
         if (line_len == 0) return 1'b1;
         // compare only up to the first nul
         n = 0;
         while (n < line_len && line_buf[n] != CHAR_NUL) n++;
         pending_replies.push_back(apply_command(
            line_equals(n, "START") || line_equals(n, "GO") || line_equals(n, "1"),
            line_equals(n, "STOP") || line_equals(n, "0")));
         line_len = 0;
         return 1'b0;
      end
      if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ch = ch - CASE_OFFSET;
      if (ch == CHAR_SPACE && line_len == 0) return 1'b1;
      if (line_len < LINE_DEPTH) begin
         line_buf[line_len] = ch;
         line_len++;
      end else begin
         line_len = 0;
         r.reply = REPLY_TOO_LONG;
         r.mode_now = run_mode;
         r.restart_follow = 1'b0;
         pending_replies.push_back(r);
      end
      return 1'b0;
   endfunction

   // entered and left at a falling edge; valid stays high for a following word
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      if (!recognize_byte(rx)) bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic hold_until_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_replies.size() != 0 && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic test_immediate_digits();
      send_byte(CHAR_ONE);
      // start while already running
      send_byte(CHAR_ONE);
      send_byte(CHAR_ZERO);
   endtask

   task automatic test_command_words();
      send_text(" go");
      send_byte(CHAR_CR);
      // empty commit
      send_byte(CHAR_LF);
      send_text("sToP");
      send_byte(CHAR_LF);
   endtask

   task automatic test_embedded_zero();
      send_byte(CHAR_NUL);
      send_text("GO");
      send_byte(CHAR_CR);
      send_text("go");
      send_byte(CHAR_NUL);
      send_text("z");
      send_byte(CHAR_CR);
   endtask

   task automatic test_overflow();
      // FF down to 00 in steps of 11 hex: sixteen words, the last one overflows
      for (int i = 0; i < 16; i++) send_byte(8'hFF - 8'(i * 17));
      send_byte(CHAR_CR);
      send_byte(CHAR_ZERO);
   endtask

   task automatic test_random_traffic(input int count, input int sender_idle,
                                      input int receiver_stall);
      int         target;
      int         kind;
      string      w;
      logic [7:0] ch;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 10) begin
            send_byte($urandom_range(1) ? CHAR_ONE : CHAR_ZERO);
         end else if (kind < 55) begin
            repeat ($urandom_range(2)) send_byte(CHAR_SPACE);
            w = cmd_words[$urandom_range(7)];
            for (int i = 0; i < w.len(); i++) begin
               ch = w[i];
               if ($urandom_range(1)) ch = ch + CASE_OFFSET;
               send_byte(ch);
            end
            if ($urandom_range(4) == 0) begin
               send_byte(CHAR_NUL);
               repeat ($urandom_range(3)) send_byte(8'($urandom_range(8'h41, 8'h5A)));
            end
            send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
            send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end else if (kind < 80) begin
            // long lines of printable words, most of them overflow
            repeat ($urandom_range(15, 18)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
            send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end else if (kind < 85) begin
            send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_immediate_digits();
      test_command_words();
      test_embedded_zero();
      test_overflow();
      hold_until_drained();
      test_random_traffic(260, 0, 0);
      hold_until_drained();
      test_random_traffic(260, 46, 0);
      hold_until_drained();
      test_random_traffic(260, 0, 46);
      hold_until_drained();
      test_random_traffic(260, 12, 12);
      hold_until_drained();
      if (pending_replies.size() != 0) begin
         $display("%0t: %0d replies missing, next expected reply %0d, actual none",
                  $time, pending_replies.size(), pending_replies[0].reply);
         errors += pending_replies.size();
      end
      $display("ran %0d command words and checked %0d replies: digits, words, nul, overflow,",
               bytes_sent, replies_checked);
      $display("then random lines under four sender/receiver idle mixes; %0d errors", errors);
      if (errors == 0) begin
         $display("** serial_command_line_recognizer_core: PASSED **");
      end else begin
         $display("** serial_command_line_recognizer_core: FAILED **");
      end
      $finish;
   end

endmodule
